### hdl/dtsf_pkg.sv
// Shared types, character codes and width helpers for the decimal text to
// single-precision converter. No dependencies.

package dtsf_pkg;

	localparam int MANTISSA_BITS = 23;
	localparam int EXP_WIDTH = 8;
	localparam int DEF_INTEGER_BITS = 31;
	localparam int DEF_MAX_FRACTION_DIGITS = 9;
	localparam int DECIMAL_RADIX = 10;

	localparam logic [EXP_WIDTH-1:0] EXP_BIAS = 8'd127;

	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_DOT = 8'h2e;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef struct packed {
		logic start;
		logic negative;
		logic error;
	} handoff_t;

	typedef struct packed {
		logic busy;
		logic done;
	} conv_status_t;

	typedef struct packed {
		logic                     format_error;
		logic [MANTISSA_BITS-1:0] mantissa;
		logic [EXP_WIDTH-1:0]     biased_exponent;
		logic                     sign;
	} result_t;

	// Number of bits needed to hold ten to the power n.
	function automatic int pow10_width(input int n);
		longint unsigned p;
		int w;
		p = 1;
		w = 0;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		for (int b = 0; b < 64; b++) begin
			if ((p >> b) != 0) begin
				w = b + 1;
			end
		end
		return w;
	endfunction

endpackage

### hdl/dtsf_accum.sv
// Character accumulator: builds the integer value, fraction value and
// fraction scale from incoming characters. Depends on dtsf_pkg.

module dtsf_accum import dtsf_pkg::*; #(
	parameter int INTEGER_BITS = DEF_INTEGER_BITS,
	parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS,
	parameter int SCALE_W = pow10_width(MAX_FRACTION_DIGITS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              character,
	input  logic                    last,
	output handoff_t                handoff,
	output logic [INTEGER_BITS-1:0] int_value,
	output logic [SCALE_W-1:0]      frac_value,
	output logic [SCALE_W-1:0]      frac_scale
);

	localparam int CNT_W = $clog2(MAX_FRACTION_DIGITS + 1);
	localparam int IP_W = INTEGER_BITS + 4;
	localparam int FP_W = SCALE_W + 4;

	logic                    first_q;
	logic                    neg_q;
	logic                    dot_q;
	logic                    err_q;
	logic [INTEGER_BITS-1:0] int_q;
	logic [SCALE_W-1:0]      frac_q;
	logic [SCALE_W-1:0]      scale_q;
	logic [CNT_W-1:0]        cnt_q;

	logic                    neg_d;
	logic                    dot_d;
	logic                    err_d;
	logic [INTEGER_BITS-1:0] int_d;
	logic [SCALE_W-1:0]      frac_d;
	logic [SCALE_W-1:0]      scale_d;
	logic [CNT_W-1:0]        cnt_d;
	logic [3:0]              digit;
	logic [IP_W-1:0]         int_prod;
	logic [FP_W-1:0]         frac_prod;
	logic [FP_W-1:0]         scale_prod;

	assign digit = 4'(character - CHAR_ZERO);
	assign int_prod = IP_W'(int_q) * IP_W'(DECIMAL_RADIX) + IP_W'(digit);
	assign frac_prod = FP_W'(frac_q) * FP_W'(DECIMAL_RADIX) + FP_W'(digit);
	assign scale_prod = FP_W'(scale_q) * FP_W'(DECIMAL_RADIX);

	always_comb begin
		neg_d = neg_q;
		dot_d = dot_q;
		err_d = err_q;
		int_d = int_q;
		frac_d = frac_q;
		scale_d = scale_q;
		cnt_d = cnt_q;
		if (character == CHAR_MINUS) begin
			if (first_q) begin
				neg_d = 1'b1;
			end else begin
				err_d = 1'b1;
			end
		end else if (character == CHAR_DOT) begin
			if (dot_q) begin
				err_d = 1'b1;
			end else begin
				dot_d = 1'b1;
			end
		end else if (character inside {[CHAR_ZERO:CHAR_NINE]}) begin
			if (!dot_q) begin
				if (int_prod[IP_W-1:INTEGER_BITS] != '0) begin
					int_d = '1;
					err_d = 1'b1;
				end else begin
					int_d = int_prod[INTEGER_BITS-1:0];
				end
			end else if (cnt_q < CNT_W'(MAX_FRACTION_DIGITS)) begin
				frac_d = frac_prod[SCALE_W-1:0];
				scale_d = scale_prod[SCALE_W-1:0];
				cnt_d = cnt_q + 1'b1;
			end else begin
				err_d = 1'b1;
			end
		end else begin
			err_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			neg_q <= 1'b0;
			dot_q <= 1'b0;
			err_q <= 1'b0;
			int_q <= '0;
			frac_q <= '0;
			scale_q <= SCALE_W'(1);
			cnt_q <= '0;
		end else if (accept) begin
			if (last) begin
				first_q <= 1'b1;
				neg_q <= 1'b0;
				dot_q <= 1'b0;
				err_q <= 1'b0;
				int_q <= '0;
				frac_q <= '0;
				scale_q <= SCALE_W'(1);
				cnt_q <= '0;
			end else begin
				first_q <= 1'b0;
				neg_q <= neg_d;
				dot_q <= dot_d;
				err_q <= err_d;
				int_q <= int_d;
				frac_q <= frac_d;
				scale_q <= scale_d;
				cnt_q <= cnt_d;
			end
		end
	end

	assign handoff.start = accept && last;
	assign handoff.negative = neg_d;
	assign handoff.error = err_d;
	assign int_value = int_d;
	assign frac_value = frac_d;
	assign frac_scale = scale_d;

endmodule

### hdl/dtsf_convert.sv
// Conversion sequencer: normalizes the integer part and produces exact
// fraction bits with one shared double, compare and subtract unit.
// Depends on dtsf_pkg.

module dtsf_convert import dtsf_pkg::*; #(
	parameter int INTEGER_BITS = DEF_INTEGER_BITS,
	parameter int SCALE_W = pow10_width(DEF_MAX_FRACTION_DIGITS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  handoff_t                handoff,
	input  logic [INTEGER_BITS-1:0] int_value,
	input  logic [SCALE_W-1:0]      frac_value,
	input  logic [SCALE_W-1:0]      frac_scale,
	input  logic                    out_free,
	output conv_status_t            status,
	output result_t                 result
);

	localparam int IL_W = $clog2(INTEGER_BITS);
	localparam int MC_W = $clog2(MANTISSA_BITS);
	localparam logic [6:0] K_CAP = 7'd64;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NORM = 3'd1;
	localparam logic [2:0] ST_LEAD = 3'd2;
	localparam logic [2:0] ST_MANT = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;

	logic [2:0]               state_q;
	logic [INTEGER_BITS-1:0]  ireg_q;
	logic [IL_W-1:0]          ileft_q;
	logic [SCALE_W-1:0]       rem_q;
	logic [SCALE_W-1:0]       scale_q;
	logic [6:0]               k_q;
	logic [MANTISSA_BITS-1:0] mant_q;
	logic [MC_W-1:0]          mcnt_q;
	logic [EXP_WIDTH-1:0]     exp_q;
	logic                     sign_q;
	logic                     err_q;

	logic [SCALE_W:0]         rem2;
	logic                     frac_bit;
	logic [SCALE_W-1:0]       rem_nx;
	logic                     mant_bit;

	// Shared unit: one exact binary digit of the fraction per use.
	assign rem2 = {rem_q, 1'b0};
	assign frac_bit = rem2 >= {1'b0, scale_q};
	assign rem_nx = frac_bit ? SCALE_W'(rem2 - {1'b0, scale_q}) : rem2[SCALE_W-1:0];
	assign mant_bit = (ileft_q != '0) ? ireg_q[INTEGER_BITS-2] : frac_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (handoff.start) begin
						if (int_value != '0) begin
							state_q <= ST_NORM;
						end else if (frac_value != '0) begin
							state_q <= ST_LEAD;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_NORM: begin
					if (ireg_q[INTEGER_BITS-1]) begin
						state_q <= ST_MANT;
					end
				end
				ST_LEAD: begin
					if (frac_bit || k_q == K_CAP) begin
						state_q <= ST_MANT;
					end
				end
				ST_MANT: begin
					if (mcnt_q == MC_W'(MANTISSA_BITS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (handoff.start) begin
					ireg_q <= int_value;
					ileft_q <= (int_value != '0) ? IL_W'(INTEGER_BITS - 1) : '0;
					rem_q <= frac_value;
					scale_q <= frac_scale;
					sign_q <= handoff.negative;
					err_q <= handoff.error;
					mant_q <= '0;
					mcnt_q <= '0;
					k_q <= 7'd1;
					exp_q <= '0;
				end
			end
			ST_NORM: begin
				if (ireg_q[INTEGER_BITS-1]) begin
					exp_q <= EXP_BIAS + EXP_WIDTH'(ileft_q);
				end else begin
					ireg_q <= {ireg_q[INTEGER_BITS-2:0], 1'b0};
					ileft_q <= ileft_q - 1'b1;
				end
			end
			ST_LEAD: begin
				rem_q <= rem_nx;
				if (frac_bit || k_q == K_CAP) begin
					exp_q <= EXP_BIAS - EXP_WIDTH'(k_q);
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			ST_MANT: begin
				mant_q <= {mant_q[MANTISSA_BITS-2:0], mant_bit};
				mcnt_q <= mcnt_q + 1'b1;
				if (ileft_q != '0) begin
					ireg_q <= {ireg_q[INTEGER_BITS-2:0], 1'b0};
					ileft_q <= ileft_q - 1'b1;
				end else begin
					rem_q <= rem_nx;
				end
			end
			default: begin
			end
		endcase
	end

	assign status.busy = state_q != ST_IDLE;
	assign status.done = (state_q == ST_FIN) && out_free;
	assign result.sign = sign_q;
	assign result.biased_exponent = exp_q;
	assign result.mantissa = mant_q;
	assign result.format_error = err_q;

endmodule

### hdl/decimal_text_to_single_float_top.sv
// Top level of the decimal text to single-precision converter.
// Depends on dtsf_pkg, dtsf_accum and dtsf_convert.
//
// Usage: characters of one number ('-', digits, '.', digits) arrive on the
// slave stream, one request per character, with tlast on the final one.
// Each character is taken while the block is idle. The request
// with tlast loads the converter and starts the conversion; s_tready stays
// low until it finishes. Normalizing the integer part shifts it until the
// leading one reaches the top bit; then come 23 mantissa steps and a
// finishing state that holds until the output register is free.
// A number without integer part instead spends one step per fraction bit up
// to the first one, at most 30 steps with nine fraction digits.
// Fraction steps use one shared double, compare and subtract unit. The
// result waits in an output register; a stalled master side holds it there
// and the next number's characters may still arrive, but the next
// conversion does not finish until the register is free.
// Reset clears all accumulated text and drops any pending result.

module decimal_text_to_single_float_top import dtsf_pkg::*; #(
	parameter int INTEGER_BITS = DEF_INTEGER_BITS,
	parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // character[7:0]
	input  logic        s_tlast,  // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // sign, biased_exponent[7:0], mantissa[22:0], format_error
);

	localparam int SCALE_W = pow10_width(MAX_FRACTION_DIGITS);

	handoff_t                handoff;
	conv_status_t            status;
	result_t                 result;
	result_t                 out_q;
	logic                    out_valid_q;
	logic                    out_free;
	logic                    accept;
	logic [INTEGER_BITS-1:0] int_value;
	logic [SCALE_W-1:0]      frac_value;
	logic [SCALE_W-1:0]      frac_scale;

	assign s_tready = !status.busy;
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	dtsf_accum #(
		.INTEGER_BITS(INTEGER_BITS),
		.MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS),
		.SCALE_W(SCALE_W)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.character(s_tdata),
		.last(s_tlast),
		.handoff(handoff),
		.int_value(int_value),
		.frac_value(frac_value),
		.frac_scale(frac_scale)
	);

	dtsf_convert #(
		.INTEGER_BITS(INTEGER_BITS),
		.SCALE_W(SCALE_W)
	) u_convert (
		.clk(clk),
		.arst_n(arst_n),
		.handoff(handoff),
		.int_value(int_value),
		.frac_value(frac_value),
		.frac_scale(frac_scale),
		.out_free(out_free),
		.status(status),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.done) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'b0, out_q.format_error, out_q.mantissa, out_q.biased_exponent,
		out_q.sign};

	// The final character of a number starts a conversion that blocks input.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> !s_tready)
		else $error("input still ready after the final character");

	// A result is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> (!out_valid_q || m_tready))
		else $error("pending result overwritten");

	// A zero exponent always comes with a zero mantissa.
	a_zero_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.biased_exponent == '0 |-> out_q.mantissa == '0)
		else $error("zero exponent with nonzero mantissa");

endmodule

### dv/float_result_checker.sv
// Checker for the decimal text to single-precision converter: watches both streams,
// predicts each converted float from the accepted characters and compares field by field.
// Depends on dtsf_pkg.

module float_result_checker import dtsf_pkg::*; #(
	parameter int INTEGER_BITS = DEF_INTEGER_BITS,
	parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	output int          fail_count,
	output int          pending_floats,
	output int          floats_seen,
	output int          chars_seen,
	output int          flagged_count
);

	localparam logic [63:0] INT_LIMIT = (64'd1 << INTEGER_BITS) - 64'd1;

	bit          at_first;
	bit          minus_seen;
	bit          dot_seen;
	bit          bad_text;
	logic [63:0] int_part;
	logic [63:0] frac_digits;
	logic [63:0] frac_scale;
	int          frac_count;
	result_t     expected_floats[$];

	task automatic report_mismatch(input string msg);
		$display("float_result_checker: float %0d: %s", floats_seen, msg);
		fail_count++;
	endtask

	task automatic clear_number();
		at_first = 1'b1;
		minus_seen = 1'b0;
		dot_seen = 1'b0;
		bad_text = 1'b0;
		int_part = '0;
		frac_digits = '0;
		frac_scale = 64'd1;
		frac_count = 0;
	endtask

	// One exact binary digit of the fraction: double the remainder, compare with the scale.
	function automatic bit next_frac_bit(inout logic [63:0] rem);
		rem = rem << 1;
		if (rem >= frac_scale) begin
			rem = rem - frac_scale;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic take_char(input logic [7:0] c);
		logic [63:0] d;
		d = 64'(c - CHAR_ZERO);
		if (c == CHAR_MINUS) begin
			if (at_first) begin
				minus_seen = 1'b1;
			end else begin
				bad_text = 1'b1;
			end
		end else if (c == CHAR_DOT) begin
			if (dot_seen) begin
				bad_text = 1'b1;
			end
			dot_seen = 1'b1;
		end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			if (!dot_seen) begin
				if (int_part > (INT_LIMIT - d) / DECIMAL_RADIX) begin
					int_part = INT_LIMIT;
					bad_text = 1'b1;
				end else begin
					int_part = int_part * DECIMAL_RADIX + d;
				end
			end else if (frac_count < MAX_FRACTION_DIGITS) begin
				frac_digits = frac_digits * DECIMAL_RADIX + d;
				frac_scale = frac_scale * DECIMAL_RADIX;
				frac_count++;
			end else begin
				bad_text = 1'b1;
			end
		end else begin
			bad_text = 1'b1;
		end
		at_first = 1'b0;
	endtask

	function automatic result_t finish_number();
		result_t                  r;
		logic [63:0]              rem;
		logic [MANTISSA_BITS-1:0] mant;
		int                       msb;
		int                       k;
		r = '0;
		mant = '0;
		rem = frac_digits;
		r.sign = minus_seen;
		r.format_error = bad_text;
		if (int_part != 0) begin
			msb = 0;
			for (int b = 0; b < 64; b++) begin
				if (int_part[b]) begin
					msb = b;
				end
			end
			r.biased_exponent = EXP_BIAS + 8'(msb);
			if (msb >= MANTISSA_BITS) begin
				mant = MANTISSA_BITS'(int_part >> (msb - MANTISSA_BITS));
			end else begin
				mant = MANTISSA_BITS'(int_part & ((64'd1 << msb) - 64'd1));
				for (int i = msb; i < MANTISSA_BITS; i++) begin
					mant = {mant[MANTISSA_BITS-2:0], next_frac_bit(rem)};
				end
			end
		end else if (frac_digits != 0) begin
			k = 1;
			while (!next_frac_bit(rem) && k < 64) begin
				k++;
			end
			r.biased_exponent = EXP_BIAS - 8'(k);
			for (int i = 0; i < MANTISSA_BITS; i++) begin
				mant = {mant[MANTISSA_BITS-2:0], next_frac_bit(rem)};
			end
		end
		r.mantissa = mant;
		return r;
	endfunction

	initial begin
		fail_count = 0;
		pending_floats = 0;
		floats_seen = 0;
		chars_seen = 0;
		flagged_count = 0;
		clear_number();
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			clear_number();
			expected_floats.delete();
			pending_floats = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (expected_floats.size() == 0) begin
					report_mismatch($sformatf("result %h with no number pending", m_tdata));
				end else begin
					want = expected_floats.pop_front();
					if (got.sign !== want.sign) begin
						report_mismatch($sformatf("sign %b, expected %b", got.sign, want.sign));
					end
					if (got.biased_exponent !== want.biased_exponent) begin
						report_mismatch($sformatf("exponent %0d, expected %0d",
							got.biased_exponent, want.biased_exponent));
					end
					if (got.mantissa !== want.mantissa) begin
						report_mismatch($sformatf("mantissa %h, expected %h",
							got.mantissa, want.mantissa));
					end
					if (got.format_error !== want.format_error) begin
						report_mismatch($sformatf("format error %b, expected %b",
							got.format_error, want.format_error));
					end
					if (m_tdata[39:$bits(result_t)] !== '0) begin
						report_mismatch($sformatf("padding bits %h not zero",
							m_tdata[39:$bits(result_t)]));
					end
				end
				floats_seen++;
			end
			if (s_tvalid && s_tready) begin
				take_char(s_tdata);
				chars_seen++;
				if (s_tlast) begin
					want = finish_number();
					if (want.format_error) begin
						flagged_count++;
					end
					expected_floats.push_back(want);
					clear_number();
				end
			end
			pending_floats = expected_floats.size();
		end
	end

endmodule

### dv/tb_top.sv
// Testbench top for the decimal text to single-precision converter: drives number text
// and the result handshake, and gives the verdict. Depends on dtsf_pkg,
// decimal_text_to_single_float_top and float_result_checker.

module tb_top;
	import dtsf_pkg::*;

	typedef logic [7:0] char_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	int fail_count;
	int pending_floats;
	int floats_seen;
	int chars_seen;
	int flagged_count;
	bit tx_calm;
	bit rx_calm;
	bit hold_off_req;
	int chars_sent;

	decimal_text_to_single_float_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	float_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_count(fail_count),
		.pending_floats(pending_floats),
		.floats_seen(floats_seen),
		.chars_seen(chars_seen),
		.flagged_count(flagged_count)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic push_char(input char_t c, input bit is_last);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= is_last;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input char_t text[$]);
		foreach (text[i]) begin
			push_char(text[i], i == text.size() - 1);
		end
	endtask

	task automatic send_string(input string s);
		char_t text[$];
		for (int i = 0; i < s.len(); i++) begin
			text.push_back(char_t'(s[i]));
		end
		send_text(text);
	endtask

	function automatic char_t rand_digit();
		if ($urandom_range(0, 3) == 0) begin
			return CHAR_ZERO;
		end
		return CHAR_ZERO + char_t'($urandom_range(0, 9));
	endfunction

	initial begin
		char_t text[$];
		int    kind;
		int    n;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		tx_calm = 1'b0;
		hold_off_req = 1'b0;
		chars_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_string("-");
		send_string("-.");
		send_text('{CHAR_ZERO, 8'hff});
		send_string("9999999999-");
		send_string(".123456789.0");

		hold_off_req = 1'b1;
		while (chars_sent < 1950) begin
			text = {};
			kind = $urandom_range(0, 9);
			tx_calm = ($urandom_range(0, 5) == 0);
			if (kind == 0) begin
				n = $urandom_range(1, 4);
				repeat (n) text.push_back(char_t'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(0, 1) == 1) begin
					text.push_back(CHAR_MINUS);
				end
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 11) : $urandom_range(0, 4);
				repeat (n) text.push_back(rand_digit());
				if ($urandom_range(0, 9) < 7) begin
					text.push_back(CHAR_DOT);
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 11) :
						$urandom_range(0, 5);
					repeat (n) text.push_back(rand_digit());
				end
				if (kind == 1) begin
					text.insert($urandom_range(0, text.size()), char_t'($urandom_range(0, 255)));
				end
				if (text.size() == 0) begin
					text.push_back(rand_digit());
				end
			end
			send_text(text);
		end
		s_tvalid <= 1'b0;

		n = 0;
		while (pending_floats != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (150) @(posedge clk);

		$display("Run covered %0d characters in %0d converted numbers, %0d of them flagged.",
			chars_seen, floats_seen, flagged_count);
		if (pending_floats != 0) begin
			$display("%0d expected results never arrived.", pending_floats);
		end
		if (fail_count == 0 && pending_floats == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// The result side stalls at random, once for a long stretch so the input backs up.
	initial begin
		int stall;
		m_tready = 1'b0;
		rx_calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 9) == 0) begin
				rx_calm = !rx_calm;
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			stall = rx_calm ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#4000000;
		$display("Run timed out.");
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

### sim.f
hdl/dtsf_pkg.sv
hdl/dtsf_accum.sv
hdl/dtsf_convert.sv
hdl/decimal_text_to_single_float_top.sv
dv/float_result_checker.sv
dv/tb_top.sv
